// ===== rtl/rsm_pkg.sv =====
`timescale 1ns / 1ps

package rsm_pkg;

  // Operation codes of an incoming item
  localparam logic [2:0] OP_VOTE_REQ    = 3'd0;
  localparam logic [2:0] OP_PRE_VOTE    = 3'd1;
  localparam logic [2:0] OP_VOTE_RESP   = 3'd2;
  localparam logic [2:0] OP_TIMEOUT     = 3'd3;
  localparam logic [2:0] OP_CONTACT     = 3'd4;
  localparam logic [2:0] OP_TIMEOUT_NOW = 3'd5;

  // Node roles
  localparam logic [1:0] ROLE_FOLLOWER  = 2'd0;
  localparam logic [1:0] ROLE_CANDIDATE = 2'd1;
  localparam logic [1:0] ROLE_LEADER    = 2'd2;

  localparam logic [4:0] TALLY_MAX = 5'd31;

  // One-hot decode of the operation; all zero for unused codes
  typedef struct packed {
    logic vote_req;
    logic pre_vote;
    logic vote_resp;
    logic timeout;
    logic contact;
    logic timeout_now;
  } op_flags_t;

  // Classified item as it travels from front to back (term carried separately)
  typedef struct packed {
    op_flags_t   op;
    logic [3:0]  sender_id;
    logic        vote_granted;
    logic [31:0] cand_last_index;
    logic [31:0] cand_last_term;
    logic [31:0] local_last_index;
    logic [31:0] local_last_term;
  } item_t;

  typedef struct packed {
    logic [31:0] reply_term;
    logic        accepted;
    logic [1:0]  role;
    logic [4:0]  known_leader;
    logic        start_vote_request;
    logic [31:0] request_last_index;
    logic [31:0] request_last_term;
  } result_t;

endpackage

// ===== rtl/raft_election_state_machine_unit.sv =====
`timescale 1ns / 1ps

// An item waits in the input queue; the back end's state update then writes its result into the result queue.
// Throughput: one item per cycle while neither queue stalls it; the back end's state update is the loop.
// Queues of two entries on each side of the back end absorb stalls independently.
// Reset (rst, synchronous, active high): term 0, follower, no vote, no leader,
// tallies and log tail cleared, node_id 0, cluster_size 1, both queues empty.
module raft_election_state_machine_unit #(
  parameter int MAX_NODES = 16,
  parameter int TERM_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,

  // APB-style configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  // item input queue side
  input  logic        push,
  output logic        full,
  input  logic [2:0]  operation,
  input  logic [31:0] msg_term,
  input  logic [3:0]  sender_id,
  input  logic        vote_granted,
  input  logic [31:0] cand_last_index,
  input  logic [31:0] cand_last_term,
  input  logic [31:0] local_last_index,
  input  logic [31:0] local_last_term,

  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic [31:0] reply_term,
  output logic        accepted,
  output logic [1:0]  role,
  output logic [4:0]  known_leader,
  output logic        start_vote_request,
  output logic [31:0] request_last_index,
  output logic [31:0] request_last_term
);

  // Register map: node_id at byte 0, cluster_size at byte 4.
  localparam logic REG_NODE_ID      = 1'b0;
  localparam logic REG_CLUSTER_SIZE = 1'b1;

  logic [3:0]           node_id;
  logic [4:0]           cluster_size;
  logic                 cfg_wr;

  logic                 q_pop;
  logic                 q_empty;
  rsm_pkg::item_t       q_item;
  logic [TERM_BITS-1:0] q_term;
  rsm_pkg::result_t     res;

  // Configuration: writes land in the access phase; reads are a plain mux.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_id      <= 4'd0;
      cluster_size <= 5'd1;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_NODE_ID:      node_id      <= pwdata[3:0];
        REG_CLUSTER_SIZE: cluster_size <= pwdata[4:0];
        default:          node_id      <= node_id;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_NODE_ID:      prdata = {28'd0, node_id};
      REG_CLUSTER_SIZE: prdata = {27'd0, cluster_size};
      default:          prdata = 32'd0;
    endcase
  end

  // Front end: decode and queue incoming items.
  rsm_front #(
    .TERM_BITS(TERM_BITS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .operation       (operation),
    .msg_term        (msg_term),
    .sender_id       (sender_id),
    .vote_granted    (vote_granted),
    .cand_last_index (cand_last_index),
    .cand_last_term  (cand_last_term),
    .local_last_index(local_last_index),
    .local_last_term (local_last_term),
    .q_pop           (q_pop),
    .q_empty         (q_empty),
    .q_item          (q_item),
    .q_term          (q_term)
  );

  // Back end: election state update and result queue.
  rsm_back #(
    .MAX_NODES(MAX_NODES),
    .TERM_BITS(TERM_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .node_id     (node_id),
    .cluster_size(cluster_size),
    .q_empty     (q_empty),
    .q_item      (q_item),
    .q_term      (q_term),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .res         (res)
  );

  assign reply_term         = res.reply_term;
  assign accepted           = res.accepted;
  assign role               = res.role;
  assign known_leader       = res.known_leader;
  assign start_vote_request = res.start_vote_request;
  assign request_last_index = res.request_last_index;
  assign request_last_term  = res.request_last_term;

endmodule

// ===== rtl/rsm_fifo.sv =====
`timescale 1ns / 1ps

module rsm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/rsm_front.sv =====
`timescale 1ns / 1ps

// Decodes the operation, trims or zero-extends the term to TERM_BITS, queues the item.
module rsm_front #(
  parameter int TERM_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [2:0]           operation,
  input  logic [31:0]          msg_term,
  input  logic [3:0]           sender_id,
  input  logic                 vote_granted,
  input  logic [31:0]          cand_last_index,
  input  logic [31:0]          cand_last_term,
  input  logic [31:0]          local_last_index,
  input  logic [31:0]          local_last_term,
  input  logic                 q_pop,
  output logic                 q_empty,
  output rsm_pkg::item_t       q_item,
  output logic [TERM_BITS-1:0] q_term
);

  localparam int TW = (TERM_BITS > 32) ? TERM_BITS : 32;
  localparam int QW = TERM_BITS + $bits(rsm_pkg::item_t);

  rsm_pkg::op_flags_t   flags;
  rsm_pkg::item_t       item;
  logic [TW-1:0]        term_wide;
  logic [TERM_BITS-1:0] term;
  logic [QW-1:0]        q_dout;

  always_comb begin
    flags = '0;
    case (operation)
      rsm_pkg::OP_VOTE_REQ:    flags.vote_req    = 1'b1;
      rsm_pkg::OP_PRE_VOTE:    flags.pre_vote    = 1'b1;
      rsm_pkg::OP_VOTE_RESP:   flags.vote_resp   = 1'b1;
      rsm_pkg::OP_TIMEOUT:     flags.timeout     = 1'b1;
      rsm_pkg::OP_CONTACT:     flags.contact     = 1'b1;
      rsm_pkg::OP_TIMEOUT_NOW: flags.timeout_now = 1'b1;
      default:                 flags = '0;
    endcase
  end

  assign term_wide = TW'(msg_term);
  assign term      = term_wide[TERM_BITS-1:0];

  always_comb begin
    item.op               = flags;
    item.sender_id        = sender_id;
    item.vote_granted     = vote_granted;
    item.cand_last_index  = cand_last_index;
    item.cand_last_term   = cand_last_term;
    item.local_last_index = local_last_index;
    item.local_last_term  = local_last_term;
  end

  rsm_fifo #(
    .WIDTH(QW),
    .DEPTH(2)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  ({term, item}),
    .full (full),
    .pop  (q_pop),
    .dout (q_dout),
    .empty(q_empty)
  );

  assign q_term = q_dout[QW-1 -: TERM_BITS];
  assign q_item = q_dout[$bits(rsm_pkg::item_t)-1:0];

endmodule

// ===== rtl/rsm_back.sv =====
`timescale 1ns / 1ps

// Election state and per-item update; one item per cycle into the result queue unless no item waits or it is full.
module rsm_back #(
  parameter int MAX_NODES = 16,
  parameter int TERM_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [3:0]           node_id,
  input  logic [4:0]           cluster_size,
  input  logic                 q_empty,
  input  rsm_pkg::item_t       q_item,
  input  logic [TERM_BITS-1:0] q_term,
  output logic                 q_pop,
  input  logic                 pop,
  output logic                 empty,
  output rsm_pkg::result_t     res
);

  localparam int NB = $clog2(MAX_NODES + 1);
  localparam int IW = (NB > 5) ? NB : 5;
  localparam int TW = (TERM_BITS > 32) ? TERM_BITS : 32;
  localparam logic [IW-1:0] NO_NODE = IW'(MAX_NODES);

  logic [TERM_BITS-1:0] current_term, current_term_next;
  logic [1:0]           node_role, node_role_next;
  logic [IW-1:0]        voted_for, voted_for_next;
  logic [4:0]           votes_for_me, votes_for_me_next;
  logic [4:0]           votes_against_me, votes_against_me_next;
  logic                 election_decided, election_decided_next;
  logic [31:0]          tail_index, tail_index_next;
  logic [31:0]          tail_term, tail_term_next;
  logic [IW-1:0]        leader_seen, leader_seen_next;

  logic                 out_full;
  logic                 advance;
  logic                 acc;
  logic                 start;
  logic                 term_lt;
  logic                 term_gt;
  logic                 up_to_date;
  logic [IW-1:0]        sender;
  logic [IW-1:0]        vote_rec;
  logic [IW-1:0]        cs_ext;
  logic [IW-1:0]        members;
  logic [IW-1:0]        quorum;
  logic [TW-1:0]        term_wide;
  rsm_pkg::result_t     result;

  assign advance = !q_empty && !out_full;
  assign q_pop   = advance;

  assign term_lt    = q_term < current_term;
  assign term_gt    = q_term > current_term;
  assign up_to_date = (q_item.cand_last_term > tail_term) ||
                      ((q_item.cand_last_term == tail_term) &&
                       (q_item.cand_last_index >= tail_index));
  assign sender     = IW'(q_item.sender_id);
  // vote record as seen after a possible term adoption
  assign vote_rec   = term_gt ? NO_NODE : voted_for;
  assign cs_ext     = IW'(cluster_size);
  assign members    = (cs_ext > IW'(MAX_NODES)) ? IW'(MAX_NODES) : cs_ext;
  assign quorum     = (members >> 1) + IW'(1);

  always_comb begin
    current_term_next     = current_term;
    node_role_next        = node_role;
    voted_for_next        = voted_for;
    votes_for_me_next     = votes_for_me;
    votes_against_me_next = votes_against_me;
    election_decided_next = election_decided;
    tail_index_next       = tail_index;
    tail_term_next        = tail_term;
    leader_seen_next      = leader_seen;
    acc                   = 1'b0;
    start                 = 1'b0;

    if (q_item.op.vote_req) begin
      if (!term_lt) begin
        if (term_gt) begin
          current_term_next = q_term;
          voted_for_next    = NO_NODE;
          node_role_next    = rsm_pkg::ROLE_FOLLOWER;
        end
        if (((vote_rec == NO_NODE) || (vote_rec == sender)) && up_to_date) begin
          voted_for_next = sender;
          acc            = 1'b1;
        end
      end
    end

    if (q_item.op.pre_vote) begin
      acc = up_to_date;
    end

    if (q_item.op.vote_resp && !election_decided) begin
      if (term_gt) begin
        current_term_next     = q_term;
        voted_for_next        = NO_NODE;
        node_role_next        = rsm_pkg::ROLE_FOLLOWER;
        election_decided_next = 1'b1;
      end else if (!term_lt && (node_role == rsm_pkg::ROLE_CANDIDATE)) begin
        if (q_item.vote_granted) begin
          if (votes_for_me != rsm_pkg::TALLY_MAX) begin
            votes_for_me_next = votes_for_me + 5'd1;
          end
        end else if (votes_against_me != rsm_pkg::TALLY_MAX) begin
          votes_against_me_next = votes_against_me + 5'd1;
        end
        if (IW'(votes_for_me_next) >= quorum) begin
          election_decided_next = 1'b1;
          node_role_next        = rsm_pkg::ROLE_LEADER;
        end
      end
    end

    if (q_item.op.timeout && (node_role != rsm_pkg::ROLE_LEADER)) begin
      // term saturates at all ones
      if (!(&current_term)) begin
        current_term_next = current_term + 1'b1;
      end
      node_role_next        = (cluster_size <= 5'd1) ? rsm_pkg::ROLE_LEADER
                                                     : rsm_pkg::ROLE_CANDIDATE;
      voted_for_next        = IW'(node_id);
      votes_for_me_next     = 5'd1;
      votes_against_me_next = 5'd0;
      election_decided_next = 1'b0;
      tail_index_next       = q_item.local_last_index;
      tail_term_next        = q_item.local_last_term;
      start                 = 1'b1;
    end

    if (q_item.op.contact && !term_lt) begin
      if (term_gt) begin
        current_term_next = q_term;
        voted_for_next    = NO_NODE;
        node_role_next    = rsm_pkg::ROLE_FOLLOWER;
      end else if (node_role == rsm_pkg::ROLE_CANDIDATE) begin
        node_role_next = rsm_pkg::ROLE_FOLLOWER;
      end
      leader_seen_next = sender;
      tail_index_next  = q_item.local_last_index;
      tail_term_next   = q_item.local_last_term;
      acc              = 1'b1;
    end

    if (q_item.op.timeout_now && !term_lt) begin
      if (term_gt) begin
        current_term_next = q_term;
        voted_for_next    = NO_NODE;
        node_role_next    = rsm_pkg::ROLE_CANDIDATE;
      end
      acc = 1'b1;
    end
  end

  assign term_wide = TW'(current_term_next);

  always_comb begin
    result.reply_term         = term_wide[31:0];
    result.accepted           = acc;
    result.role               = node_role_next;
    result.known_leader       = leader_seen_next[4:0];
    result.start_vote_request = start;
    result.request_last_index = start ? tail_index_next : 32'd0;
    result.request_last_term  = start ? tail_term_next : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_term     <= '0;
      node_role        <= rsm_pkg::ROLE_FOLLOWER;
      voted_for        <= NO_NODE;
      votes_for_me     <= '0;
      votes_against_me <= '0;
      election_decided <= 1'b0;
      tail_index       <= '0;
      tail_term        <= '0;
      leader_seen      <= NO_NODE;
    end else if (advance) begin
      current_term     <= current_term_next;
      node_role        <= node_role_next;
      voted_for        <= voted_for_next;
      votes_for_me     <= votes_for_me_next;
      votes_against_me <= votes_against_me_next;
      election_decided <= election_decided_next;
      tail_index       <= tail_index_next;
      tail_term        <= tail_term_next;
      leader_seen      <= leader_seen_next;
    end
  end

  rsm_fifo #(
    .WIDTH($bits(rsm_pkg::result_t)),
    .DEPTH(2)
  ) u_out_queue (
    .clk  (clk),
    .rst  (rst),
    .push (advance),
    .din  (result),
    .full (out_full),
    .pop  (pop),
    .dout (res),
    .empty(empty)
  );

endmodule

// ===== tb/sv/raft_vote_checker.sv =====
`timescale 1ns / 1ps

module raft_vote_checker
  import rsm_pkg::*;
#(
  parameter int MAX_NODES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        push,
  input  logic        full,
  input  logic [2:0]  operation,
  input  logic [31:0] msg_term,
  input  logic [3:0]  sender_id,
  input  logic        vote_granted,
  input  logic [31:0] cand_last_index,
  input  logic [31:0] cand_last_term,
  input  logic [31:0] local_last_index,
  input  logic [31:0] local_last_term,
  input  logic        empty,
  input  logic        pop,
  input  logic [31:0] reply_term,
  input  logic        accepted,
  input  logic [1:0]  role,
  input  logic [4:0]  known_leader,
  input  logic        start_vote_request,
  input  logic [31:0] request_last_index,
  input  logic [31:0] request_last_term,
  output int          pending,
  output int          mismatches
);

  localparam logic [2:0]  REG_NODE_ID      = 3'd0;
  localparam logic [2:0]  REG_CLUSTER_SIZE = 3'd4;
  localparam logic [4:0]  NO_NODE          = 5'd16;
  localparam logic [31:0] TERM_TOP         = 32'hFFFF_FFFF;

  // node configuration
  logic [3:0]  cfg_node;
  logic [4:0]  cfg_size;

  // election state
  logic [31:0] term_now;
  logic [1:0]  role_now;
  logic [4:0]  vote_cast;
  logic [4:0]  tally_yes;
  logic [4:0]  tally_no;
  logic        decided;
  logic [31:0] tail_idx;
  logic [31:0] tail_trm;
  logic [4:0]  leader_now;

  result_t expected_replies[$];

  task automatic clear_election();
    cfg_node   = '0;
    cfg_size   = 5'd1;
    term_now   = '0;
    role_now   = ROLE_FOLLOWER;
    vote_cast  = NO_NODE;
    tally_yes  = '0;
    tally_no   = '0;
    decided    = 1'b0;
    tail_idx   = '0;
    tail_trm   = '0;
    leader_now = NO_NODE;
  endtask

  function automatic logic log_ok(input logic [31:0] cidx, input logic [31:0] cterm);
    return (cterm > tail_trm) || (cterm == tail_trm && cidx >= tail_idx);
  endfunction

  task automatic adopt_higher_term(input logic [31:0] t);
    term_now  = t;
    vote_cast = NO_NODE;
    role_now  = ROLE_FOLLOWER;
  endtask

  task automatic advance_election(input logic [2:0] op, input logic [31:0] mterm,
                                  input logic [3:0] src, input logic yes,
                                  input logic [31:0] cidx, input logic [31:0] cterm,
                                  input logic [31:0] lidx, input logic [31:0] lterm,
                                  output result_t r);
    logic acc;
    logic start;
    int   quorum;
    acc    = 1'b0;
    start  = 1'b0;
    quorum = ((int'(cfg_size) > MAX_NODES) ? MAX_NODES : int'(cfg_size)) / 2 + 1;
    case (op)
      OP_VOTE_REQ: begin
        if (mterm >= term_now) begin
          if (mterm > term_now) adopt_higher_term(mterm);
          if ((vote_cast == NO_NODE || vote_cast == {1'b0, src}) && log_ok(cidx, cterm)) begin
            vote_cast = {1'b0, src};
            acc       = 1'b1;
          end
        end
      end
      OP_PRE_VOTE: acc = log_ok(cidx, cterm);
      OP_VOTE_RESP: begin
        if (!decided) begin
          if (mterm > term_now) begin
            adopt_higher_term(mterm);
            decided = 1'b1;
          end else if (mterm == term_now && role_now == ROLE_CANDIDATE) begin
            if (yes) begin
              if (tally_yes != TALLY_MAX) tally_yes++;
            end else begin
              if (tally_no != TALLY_MAX) tally_no++;
            end
            if (int'(tally_yes) >= quorum) begin
              decided  = 1'b1;
              role_now = ROLE_LEADER;
            end
          end
        end
      end
      OP_TIMEOUT: begin
        if (role_now != ROLE_LEADER) begin
          if (term_now != TERM_TOP) term_now++;
          role_now  = ROLE_CANDIDATE;
          vote_cast = {1'b0, cfg_node};
          tally_yes = 5'd1;
          tally_no  = '0;
          decided   = 1'b0;
          tail_idx  = lidx;
          tail_trm  = lterm;
          start     = 1'b1;
          if (cfg_size <= 5'd1) role_now = ROLE_LEADER;
        end
      end
      OP_CONTACT: begin
        if (mterm >= term_now) begin
          if (mterm > term_now) adopt_higher_term(mterm);
          else if (role_now == ROLE_CANDIDATE) role_now = ROLE_FOLLOWER;
          leader_now = {1'b0, src};
          tail_idx   = lidx;
          tail_trm   = lterm;
          acc        = 1'b1;
        end
      end
      OP_TIMEOUT_NOW: begin
        if (mterm >= term_now) begin
          if (mterm > term_now) begin
            adopt_higher_term(mterm);
            role_now = ROLE_CANDIDATE;
          end
          acc = 1'b1;
        end
      end
      default: ;
    endcase
    r.reply_term         = term_now;
    r.accepted           = acc;
    r.role               = role_now;
    r.known_leader       = leader_now;
    r.start_vote_request = start;
    r.request_last_index = start ? tail_idx : '0;
    r.request_last_term  = start ? tail_trm : '0;
  endtask

  task automatic flag(input string field, input logic [31:0] want, input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s expected %h, got %h", $time, field, want, got);
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      clear_election();
      expected_replies.delete();
    end else begin
      // results first: an item pushed at this edge cannot pop here
      if (pop && !empty) begin
        if (expected_replies.size() == 0) begin
          flag("unexpected reply_term", '0, reply_term);
        end else begin
          want = expected_replies.pop_front();
          if (reply_term !== want.reply_term) flag("reply_term", want.reply_term, reply_term);
          if (accepted !== want.accepted)
            flag("accepted", 32'(want.accepted), 32'(accepted));
          if (role !== want.role) flag("role", 32'(want.role), 32'(role));
          if (known_leader !== want.known_leader)
            flag("known_leader", 32'(want.known_leader), 32'(known_leader));
          if (start_vote_request !== want.start_vote_request)
            flag("start_vote_request", 32'(want.start_vote_request),
                 32'(start_vote_request));
          if (request_last_index !== want.request_last_index)
            flag("request_last_index", want.request_last_index, request_last_index);
          if (request_last_term !== want.request_last_term)
            flag("request_last_term", want.request_last_term, request_last_term);
        end
      end
      if (push && !full) begin
        advance_election(operation, msg_term, sender_id, vote_granted, cand_last_index,
                         cand_last_term, local_last_index, local_last_term, want);
        expected_replies.insert(expected_replies.size(), want);
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          REG_NODE_ID:      cfg_node = pwdata[3:0];
          REG_CLUSTER_SIZE: cfg_size = pwdata[4:0];
          default: ;
        endcase
      end
    end
    pending = expected_replies.size();
  end

endmodule

// ===== tb/sv/raft_election_state_machine_unit_test.sv =====
`timescale 1ns / 1ps

module raft_election_state_machine_unit_test;
  import rsm_pkg::*;

  localparam logic [2:0] REG_NODE_ID      = 3'd0;
  localparam logic [2:0] REG_CLUSTER_SIZE = 3'd4;
  localparam logic [2:0] OP_UNUSED_LO     = 3'd6;   // codes past the last operation
  localparam logic [2:0] OP_UNUSED_HI     = 3'd7;
  localparam int         CYCLE_LIMIT      = 200000;
  localparam int         PHASES           = 8;
  localparam int         ITEMS_PER_PHASE  = 125;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        push;
  logic        full;
  logic [2:0]  operation;
  logic [31:0] msg_term;
  logic [3:0]  sender_id;
  logic        vote_granted;
  logic [31:0] cand_last_index;
  logic [31:0] cand_last_term;
  logic [31:0] local_last_index;
  logic [31:0] local_last_term;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] reply_term;
  logic        accepted;
  logic [1:0]  role;
  logic [4:0]  known_leader;
  logic        start_vote_request;
  logic [31:0] request_last_index;
  logic [31:0] request_last_term;

  int pending;
  int mismatches;

  // idle knobs, percent of cycles
  int send_idle  = 0;
  int recv_stall = 0;

  // Stimulus-side shadow: term_hint never falls below the block's term, so
  // hint + 1 is always a fresh higher term. Tail copy only biases the
  // candidate log fields toward the up-to-date boundary.
  logic [31:0] term_hint = '0;
  logic [31:0] tail_i    = '0;
  logic [31:0] tail_t    = '0;
  int          sent      = 0;
  int          cycles    = 0;

  // per-phase node id / cluster size; extremes and out-of-range sizes included
  int phase_node[PHASES] = '{0, 15, 3, 9, 7, 12, 1, 4};
  int phase_size[PHASES] = '{1, 16, 0, 31, 5, 2, 17, 3};

  raft_election_state_machine_unit i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .full(full), .operation(operation), .msg_term(msg_term),
    .sender_id(sender_id), .vote_granted(vote_granted),
    .cand_last_index(cand_last_index), .cand_last_term(cand_last_term),
    .local_last_index(local_last_index), .local_last_term(local_last_term),
    .empty(empty), .pop(pop), .reply_term(reply_term), .accepted(accepted),
    .role(role), .known_leader(known_leader), .start_vote_request(start_vote_request),
    .request_last_index(request_last_index), .request_last_term(request_last_term)
  );

  raft_vote_checker i_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .push(push), .full(full), .operation(operation), .msg_term(msg_term),
    .sender_id(sender_id), .vote_granted(vote_granted),
    .cand_last_index(cand_last_index), .cand_last_term(cand_last_term),
    .local_last_index(local_last_index), .local_last_term(local_last_term),
    .empty(empty), .pop(pop), .reply_term(reply_term), .accepted(accepted),
    .role(role), .known_leader(known_leader), .start_vote_request(start_vote_request),
    .request_last_index(request_last_index), .request_last_term(request_last_term),
    .pending(pending), .mismatches(mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stalls, one assignment per falling edge
  always @(negedge clk) begin
    pop <= ($urandom_range(99) >= recv_stall);
  end

  // random sender id and random single bit
  function automatic logic [3:0] rand_id();
    return 4'($urandom);
  endfunction

  function automatic logic coin();
    return 1'($urandom);
  endfunction

  // One item; returns at the falling edge after acceptance with push still
  // high, so the caller either sends again or drops push in that same step.
  task automatic send(input logic [2:0] op, input logic [31:0] term, input logic [3:0] src,
                      input logic yes, input logic [31:0] cidx, input logic [31:0] cterm,
                      input logic [31:0] lidx, input logic [31:0] lterm);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push             <= 1'b1;
    operation        <= op;
    msg_term         <= term;
    sender_id        <= src;
    vote_granted     <= yes;
    cand_last_index  <= cidx;
    cand_last_term   <= cterm;
    local_last_index <= lidx;
    local_last_term  <= lterm;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    // pre-vote never moves the term; unused codes change nothing
    if (op != OP_PRE_VOTE && op != OP_TIMEOUT && op <= OP_TIMEOUT_NOW && term > term_hint)
      term_hint = term;
    if (op == OP_TIMEOUT && term_hint != 32'hFFFF_FFFF) term_hint++;
    if (op == OP_TIMEOUT || op == OP_CONTACT) begin
      tail_i = lidx;
      tail_t = lterm;
    end
    if (op <= OP_TIMEOUT_NOW) sent++;
  endtask

  // wait for every outstanding result, then settle
  task automatic drain();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // setup + access, then psel and penable drop so the next write starts fresh
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
    push    <= 1'b0;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // values around the up-to-date boundary, sometimes anything
  function automatic logic [31:0] jitter(input logic [31:0] x);
    case ($urandom_range(3))
      0:       return x - 32'd1;
      1:       return x;
      2:       return x + 32'd1;
      default: return $urandom();
    endcase
  endfunction

  // Contact at a fresh term, sometimes a vote request, a timeout to start an
  // election, then a run of vote responses at the current term mixed with interfering traffic.
  task automatic random_election();
    int k;
    int yes_pct;
    send(OP_CONTACT, term_hint + 1 + $urandom_range(2), rand_id(), coin(),
         $urandom, $urandom, $urandom, $urandom);
    if ($urandom_range(3) == 0)
      send(OP_VOTE_REQ, term_hint, rand_id(), coin(), jitter(tail_i), jitter(tail_t),
           $urandom, $urandom);
    send(OP_TIMEOUT, $urandom_range(term_hint), rand_id(), coin(),
         $urandom, $urandom, $urandom, $urandom);
    // occasionally a long run of mostly refusals to drive the against tally up
    k       = ($urandom_range(15) == 0) ? 35 : $urandom_range(1, 12);
    yes_pct = (k == 35) ? 5 : $urandom_range(100);
    repeat (k) begin
      case ($urandom_range(19))
        13: send(OP_VOTE_RESP, $urandom_range(1) ? term_hint - 1 : term_hint + 1, rand_id(),
                 coin(), $urandom, $urandom, $urandom, $urandom);
        14: send(OP_VOTE_REQ, term_hint + $urandom_range(1), rand_id(), coin(),
                 jitter(tail_i), jitter(tail_t), $urandom, $urandom);
        15: send(OP_PRE_VOTE, $urandom, rand_id(), coin(), jitter(tail_i), jitter(tail_t),
                 $urandom, $urandom);
        16: send(OP_CONTACT, term_hint, rand_id(), coin(), $urandom, $urandom,
                 $urandom, $urandom);
        17: send(OP_TIMEOUT_NOW, term_hint + $urandom_range(1), rand_id(), coin(),
                 $urandom, $urandom, $urandom, $urandom);
        18: send(OP_TIMEOUT, $urandom, rand_id(), coin(), $urandom, $urandom,
                 $urandom, $urandom);
        19: send($urandom_range(1) ? OP_UNUSED_LO : OP_UNUSED_HI, $urandom, rand_id(),
                 coin(), $urandom, $urandom, $urandom, $urandom);
        default: send(OP_VOTE_RESP, term_hint, rand_id(), $urandom_range(99) < yes_pct,
                      $urandom, $urandom, $urandom, $urandom);
      endcase
    end
  endtask

  // single item of any code; terms current, one above, or random up to current
  task automatic random_noise();
    logic [31:0] t;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: t = term_hint;
      5, 6:          t = term_hint + 1;
      default:       t = $urandom_range(term_hint);
    endcase
    send(3'($urandom_range(7)), t, rand_id(), coin(), jitter(tail_i), jitter(tail_t),
         $urandom, $urandom);
  endtask

  initial begin
    int target;
    // every input known from time zero
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    push             = 1'b0;
    operation        = OP_VOTE_REQ;
    msg_term         = '0;
    sender_id        = '0;
    vote_granted     = 1'b0;
    cand_last_index  = '0;
    cand_last_term   = '0;
    local_last_index = '0;
    local_last_term  = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: node 5 in a three-node cluster, majority is two
    write_reg(REG_NODE_ID, 32'd5);
    write_reg(REG_CLUSTER_SIZE, 32'd3);
    send(OP_UNUSED_LO, 32'd7, 4'd1, 1'b1, '1, '1, '1, '1);     // unused codes: no effect
    send(OP_UNUSED_HI, '1, 4'd15, 1'b0, '0, '0, '0, '0);
    send(OP_PRE_VOTE, '0, 4'd0, 1'b0, '0, '0, '0, '0);         // equal tails grant
    send(OP_PRE_VOTE, '1, 4'd15, 1'b1, '1, '1, '1, '1);
    send(OP_VOTE_REQ, 32'd1, 4'd2, 1'b0, '0, '0, '0, '0);      // higher term, vote cast
    send(OP_VOTE_REQ, 32'd1, 4'd3, 1'b0, '1, '1, '0, '0);      // already voted for 2
    send(OP_VOTE_REQ, 32'd0, 4'd2, 1'b0, '1, '1, '0, '0);      // stale term
    send(OP_CONTACT, 32'd1, 4'd4, 1'b0, '0, '0, '1, '1);       // tail latched at max
    send(OP_PRE_VOTE, 32'd1, 4'd6, 1'b0, '1, 32'hFFFF_FFFE, '0, '0); // older log refused
    send(OP_TIMEOUT, '0, 4'd0, 1'b0, '0, '0, 32'd100, 32'd7);  // election at term 2
    send(OP_VOTE_RESP, 32'd2, 4'd1, 1'b0, '0, '0, '0, '0);     // refusal
    send(OP_VOTE_RESP, 32'd2, 4'd2, 1'b1, '0, '0, '0, '0);     // majority reached
    send(OP_VOTE_RESP, 32'd9, 4'd3, 1'b1, '0, '0, '0, '0);     // decided: ignored
    send(OP_TIMEOUT, '0, 4'd0, 1'b0, '0, '0, 32'd5, 32'd5);    // leader ignores timeout
    send(OP_CONTACT, 32'd2, 4'd7, 1'b0, '0, '0, 32'd100, 32'd7); // leader same term stays
    send(OP_TIMEOUT_NOW, 32'd2, 4'd7, 1'b0, '0, '0, '0, '0);
    send(OP_TIMEOUT_NOW, 32'd3, 4'd7, 1'b0, '0, '0, '0, '0);   // adopt, become candidate
    send(OP_CONTACT, 32'd3, 4'd8, 1'b0, '0, '0, 32'd100, 32'd7); // candidate steps down
    send(OP_TIMEOUT, '0, 4'd0, 1'b0, '0, '0, 32'd200, 32'd8);  // term 4
    send(OP_VOTE_RESP, 32'd5, 4'd1, 1'b0, '0, '0, '0, '0);     // higher term decides
    send(OP_VOTE_RESP, 32'd5, 4'd2, 1'b1, '0, '0, '0, '0);     // ignored once decided
    send(OP_TIMEOUT, '0, 4'd0, 1'b0, '0, '0, 32'd201, 32'd8);  // term 6
    send(OP_VOTE_RESP, 32'd5, 4'd2, 1'b1, '0, '0, '0, '0);     // stale response
    send(OP_TIMEOUT_NOW, 32'd1, 4'd2, 1'b0, '0, '0, '0, '0);   // stale, refused

    // random phases, each under its own configuration and idle pattern
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      write_reg(REG_NODE_ID, 32'(phase_node[ph]));
      write_reg(REG_CLUSTER_SIZE, 32'(phase_size[ph]));
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 49; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 49; end
        default: begin send_idle = 33; recv_stall = 33; end
      endcase
      target = sent + ITEMS_PER_PHASE;
      while (sent < target) begin
        if ($urandom_range(9) < 6) random_election();
        else random_noise();
        // mid-phase hold-off until the block has answered everything
        if (ph == 2 && sent >= target - ITEMS_PER_PHASE / 2 &&
            sent < target - ITEMS_PER_PHASE / 2 + 15) drain();
      end
    end

    // term saturation, last because the term never comes back down
    drain();
    write_reg(REG_NODE_ID, 32'd15);
    write_reg(REG_CLUSTER_SIZE, 32'd16);
    send_idle  = 20;
    recv_stall = 20;
    send(OP_CONTACT, 32'hFFFF_FFFE, 4'd9, 1'b1, '0, '0, 32'h8000_0000, 32'h8000_0000);
    send(OP_TIMEOUT, '0, 4'd0, 1'b0, '0, '0, 32'hDEAD_BEEF, 32'hFFFF_FFFF);
    send(OP_TIMEOUT, '0, 4'd0, 1'b0, '0, '0, 32'h1234_5678, 32'hFFFF_FFFF); // stays at max
    send(OP_VOTE_RESP, '1, 4'd3, 1'b1, '0, '0, '0, '0);
    send(OP_VOTE_RESP, '1, 4'd4, 1'b0, '0, '0, '0, '0);
    send(OP_VOTE_REQ, '1, 4'd15, 1'b0, '1, '1, '0, '0);        // own id holds the vote
    send(OP_PRE_VOTE, '1, 4'd2, 1'b0, '0, '1, '0, '0);
    send(OP_TIMEOUT_NOW, '1, 4'd2, 1'b0, '0, '0, '0, '0);
    send(OP_CONTACT, '1, 4'd15, 1'b0, '1, '1, '1, '1);

    drain();
    repeat (4) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
